// ===== design/spht_pkg.sv =====
// Shared types, constants and command tables for the stalk press/hold translator.
package spht_pkg;

    // Time base and queue sizing
    localparam int TIME_BITS = 32;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Stalk button codes
    localparam logic [7:0] BTN_UP   = 8'h22;
    localparam logic [7:0] BTN_DOWN = 8'h23;
    localparam logic [7:0] BTN_OK   = 8'h28;

    // Cluster command codes and arguments
    localparam logic [7:0] CMD_HOLD_OK   = 8'h01;
    localparam logic [7:0] CMD_HOLD_DOWN = 8'h02;
    localparam logic [7:0] CMD_HOLD_UP   = 8'h03;
    localparam logic [7:0] CMD_SCROLL    = 8'h06;
    localparam logic [7:0] CMD_SELECT    = 8'h07;
    localparam logic [7:0] ARG_ONE       = 8'h01;
    localparam logic [7:0] ARG_DOWN      = 8'h0F;
    localparam logic [7:0] OUT_TRAILER   = 8'h11;
    localparam logic [7:0] STALK_TRAILER = 8'h01;
    localparam logic [3:0] STALK_LENGTH  = 4'd4;

    // Register reset values
    localparam logic        RST_ENABLE     = 1'b1;
    localparam logic [15:0] RST_HOLD_TIME  = 16'd650;
    localparam logic [15:0] RST_TIMEOUT    = 16'd1000;
    localparam logic [15:0] RST_DURATION   = 16'd120;
    localparam logic [10:0] RST_STALK_ID   = 11'h5C1;
    localparam logic [10:0] RST_CLUSTER_ID = 11'h5BF;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_HOLD_TIME  = 3'd1,
        REG_TIMEOUT    = 3'd2,
        REG_DURATION   = 3'd3,
        REG_STALK_ID   = 3'd4,
        REG_CLUSTER_ID = 3'd5
    } reg_idx_t;

    // Configuration seen by the front part
    typedef struct packed {
        logic        translate_enable;
        logic [15:0] hold_time;
        logic [15:0] release_timeout;
        logic [15:0] press_duration;
        logic [10:0] stalk_id;
        logic [10:0] cluster_id;
    } cfg_t;

    // One queued request: optional release first, then the command bytes
    typedef struct packed {
        logic       pre_release;
        logic [7:0] byte0;
        logic [7:0] byte2;
    } cmd_entry_t;

    // Queue status toward the front and back parts and checks
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } q_status_t;

    // Command lookup result
    typedef struct packed {
        logic       valid;
        logic [7:0] byte0;
        logic [7:0] byte2;
    } action_t;

    function automatic logic is_button(input logic [7:0] code);
        return (code == BTN_UP) || (code == BTN_DOWN) || (code == BTN_OK);
    endfunction

    function automatic action_t short_action(input logic [7:0] btn);
        action_t a;
        a = '0;
        unique case (btn)
            BTN_UP:   a = '{valid: 1'b1, byte0: CMD_SCROLL, byte2: ARG_ONE};
            BTN_DOWN: a = '{valid: 1'b1, byte0: CMD_SCROLL, byte2: ARG_DOWN};
            BTN_OK:   a = '{valid: 1'b1, byte0: CMD_SELECT, byte2: ARG_ONE};
            default:  a = '0;
        endcase
        return a;
    endfunction

    function automatic action_t hold_action(input logic [7:0] btn);
        action_t a;
        a = '0;
        unique case (btn)
            BTN_UP:   a = '{valid: 1'b1, byte0: CMD_HOLD_UP,   byte2: ARG_ONE};
            BTN_DOWN: a = '{valid: 1'b1, byte0: CMD_HOLD_DOWN, byte2: ARG_ONE};
            BTN_OK:   a = '{valid: 1'b1, byte0: CMD_HOLD_OK,   byte2: ARG_ONE};
            default:  a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/spht_front.sv =====
// Front part: accepts frames and ticks, tracks the held button, queues requests.
module spht_front import spht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [28:0] in_ident,
    input  logic        in_extended,
    input  logic        in_remote,
    input  logic [3:0]  in_length,
    input  logic [7:0]  in_data0,
    input  logic [7:0]  in_data1,
    input  logic [7:0]  in_data2,
    input  logic [7:0]  in_data3,
    input  q_status_t   q_stat,
    output logic        push,
    output cmd_entry_t  push_entry
);

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 active_reg, active_next;
    logic                 hold_done_reg, hold_done_next;
    logic [7:0]           held_reg, held_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] seen_reg, seen_next;
    logic                 pending_reg, pending_next;
    logic [15:0]          left_reg, left_next;

    logic                 accept;
    logic [TIME_BITS-1:0] since_seen;
    logic [TIME_BITS-1:0] since_press;
    logic                 timed_out;
    logic                 active_eff;
    logic                 hold_eff;
    logic                 shape_ok;
    logic [15:0]          left_dec;
    logic [15:0]          dur_eff;
    action_t              cmd;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Elapsed times, modulo the time width
    assign since_seen  = now_reg - seen_reg;
    assign since_press = now_reg - press_reg;
    assign timed_out   = active_reg &&
                         (since_seen > {{(TIME_BITS-16){1'b0}}, cfg.release_timeout});
    assign active_eff  = active_reg && !timed_out;
    assign hold_eff    = hold_done_reg && !timed_out;

    // Stalk frame shape
    assign shape_ok = !in_extended &&
                      (in_ident == {18'd0, cfg.stalk_id}) &&
                      (in_length == STALK_LENGTH) &&
                      (in_data1 == 8'd0) && (in_data2 == 8'd0) &&
                      (in_data3 == STALK_TRAILER);

    assign left_dec = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
    assign dur_eff  = (cfg.press_duration == 16'd0) ? 16'd1 : cfg.press_duration;

    // Next state and queued request
    always_comb
    begin
        now_next       = now_reg;
        active_next    = active_reg;
        hold_done_next = hold_done_reg;
        held_next      = held_reg;
        press_next     = press_reg;
        seen_next      = seen_reg;
        pending_next   = pending_reg;
        left_next      = left_reg;
        push           = 1'b0;
        push_entry     = '0;
        cmd            = '0;

        if (accept)
        begin
            if (in_op)
            begin
                // Tick: advance time, count down a pending release and queue it when the count runs out
                now_next = now_reg + {{(TIME_BITS-1){1'b0}}, 1'b1};
                if (pending_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        pending_next = 1'b0;
                        push         = 1'b1;
                    end
                end
            end
            else if (cfg.translate_enable && !in_remote)
            begin
                active_next    = active_eff;
                hold_done_next = hold_eff;
                if (shape_ok && in_data0 == 8'd0)
                begin
                    // Release frame: short action unless hold already went out
                    if (active_eff && !hold_eff)
                    begin
                        cmd = short_action(held_reg);
                    end
                    active_next    = 1'b0;
                    hold_done_next = 1'b0;
                end
                else if (shape_ok && is_button(in_data0))
                begin
                    if (!active_eff || held_reg != in_data0)
                    begin
                        // New press
                        active_next    = 1'b1;
                        hold_done_next = 1'b0;
                        held_next      = in_data0;
                        press_next     = now_reg;
                        seen_next      = now_reg;
                    end
                    else
                    begin
                        // Repeat of the held button
                        seen_next = now_reg;
                        if (!hold_eff &&
                            since_press >= {{(TIME_BITS-16){1'b0}}, cfg.hold_time})
                        begin
                            cmd            = hold_action(held_reg);
                            hold_done_next = 1'b1;
                        end
                    end
                end

                // Flush a pending release ahead of the command, then rearm
                if (cmd.valid)
                begin
                    push                   = 1'b1;
                    push_entry.pre_release = pending_reg;
                    push_entry.byte0       = cmd.byte0;
                    push_entry.byte2       = cmd.byte2;
                    pending_next           = 1'b1;
                    left_next              = dur_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            active_reg    <= 1'b0;
            hold_done_reg <= 1'b0;
            held_reg      <= '0;
            press_reg     <= '0;
            seen_reg      <= '0;
            pending_reg   <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            now_reg       <= now_next;
            active_reg    <= active_next;
            hold_done_reg <= hold_done_next;
            held_reg      <= held_next;
            press_reg     <= press_next;
            seen_reg      <= seen_next;
            pending_reg   <= pending_next;
            left_reg      <= left_next;
        end
    end

endmodule

// ===== design/spht_queue.sv =====
// Request queue between the front and back parts.
module spht_queue import spht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_entry_t push_entry,
    input  logic       pop,
    output cmd_entry_t head,
    output q_status_t  stat
);

    cmd_entry_t           entries_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign stat.full  = (count_reg == QCNT_BITS'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;
    assign head    = entries_reg[rd_ptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_BITS'(1);
            end
        end
    end

endmodule

// ===== design/spht_back.sv =====
// Back part: expands queued requests into cluster frames on an output register.
module spht_back import spht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_entry_t head,
    input  q_status_t  q_stat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte2,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic       rel_sent_reg, rel_sent_next;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte2_reg, byte2_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    // Pick the next result: pending release first, then the command
    always_comb
    begin
        valid_next    = valid_reg;
        rel_sent_next = rel_sent_reg;
        byte0_next    = byte0_reg;
        byte2_next    = byte2_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        if (load)
        begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                if (head.pre_release && !rel_sent_reg)
                begin
                    byte0_next    = 8'd0;
                    byte2_next    = 8'd0;
                    last_next     = 1'b0;
                    rel_sent_next = 1'b1;
                end
                else
                begin
                    byte0_next    = head.byte0;
                    byte2_next    = head.byte2;
                    last_next     = 1'b1;
                    rel_sent_next = 1'b0;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            rel_sent_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rel_sent_reg <= rel_sent_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte2_reg <= byte2_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte0 = byte0_reg;
    assign out_byte2 = byte2_reg;
    assign out_last  = last_reg;

endmodule

// ===== design/stalk_press_hold_translator.sv =====
// An accepted request is written into the request queue, then loaded into the back
// part's output register, which drives m_tvalid and m_tlast.
// Throughput: one input request per cycle while the request queue is not full;
// requests giving two frames are absorbed by the four-entry queue between front and back.
// Reset (rst_n, asynchronous, active low) clears time, press state, queue and
// output; registers return to enable 1, hold 650, timeout 1000, duration 120.
module stalk_press_hold_translator import spht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // [28:0] frame_ident, [29] extended, [30] remote, [34:31] length,
    // [42:35] data0, [50:43] data1, [58:51] data2, [66:59] data3, [71:67] zero
    input  logic [71:0] s_tdata,
    // [0] op
    input  logic        s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] out_ident, [18:11] out_byte0, [26:19] out_byte1,
    // [34:27] out_byte2, [42:35] out_byte3, [47:43] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    reg_idx_t   reg_idx;
    logic       cfg_write;
    q_status_t  q_stat;
    logic       push;
    cmd_entry_t push_entry;
    logic       pop;
    cmd_entry_t head;
    logic [7:0] out_byte0;
    logic [7:0] out_byte2;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.translate_enable <= RST_ENABLE;
            cfg_reg.hold_time        <= RST_HOLD_TIME;
            cfg_reg.release_timeout  <= RST_TIMEOUT;
            cfg_reg.press_duration   <= RST_DURATION;
            cfg_reg.stalk_id         <= RST_STALK_ID;
            cfg_reg.cluster_id       <= RST_CLUSTER_ID;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ENABLE:     cfg_reg.translate_enable <= pwdata[0];
                REG_HOLD_TIME:  cfg_reg.hold_time        <= pwdata[15:0];
                REG_TIMEOUT:    cfg_reg.release_timeout  <= pwdata[15:0];
                REG_DURATION:   cfg_reg.press_duration   <= pwdata[15:0];
                REG_STALK_ID:   cfg_reg.stalk_id         <= pwdata[10:0];
                REG_CLUSTER_ID: cfg_reg.cluster_id       <= pwdata[10:0];
                default:        ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:     prdata = {31'd0, cfg_reg.translate_enable};
            REG_HOLD_TIME:  prdata = {16'd0, cfg_reg.hold_time};
            REG_TIMEOUT:    prdata = {16'd0, cfg_reg.release_timeout};
            REG_DURATION:   prdata = {16'd0, cfg_reg.press_duration};
            REG_STALK_ID:   prdata = {21'd0, cfg_reg.stalk_id};
            REG_CLUSTER_ID: prdata = {21'd0, cfg_reg.cluster_id};
            default:        prdata = 32'd0;
        endcase
    end

    spht_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_ident    (s_tdata[28:0]),
        .in_extended (s_tdata[29]),
        .in_remote   (s_tdata[30]),
        .in_length   (s_tdata[34:31]),
        .in_data0    (s_tdata[42:35]),
        .in_data1    (s_tdata[50:43]),
        .in_data2    (s_tdata[58:51]),
        .in_data3    (s_tdata[66:59]),
        .q_stat      (q_stat),
        .push        (push),
        .push_entry  (push_entry)
    );

    spht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    spht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte0 (out_byte0),
        .out_byte2 (out_byte2),
        .out_last  (m_tlast)
    );

    // Assemble the outgoing frame
    assign m_tdata = {5'd0, OUT_TRAILER, out_byte2, 8'd0, out_byte0, cfg_reg.cluster_id};

    // Queue never overfills and the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.count <= QCNT_BITS'(QDEPTH)) && !(push && q_stat.full))
        else $error("request queue overflow");

    // A frame that is not the last of its request is always a release
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[18:11] == 8'd0 && m_tdata[34:27] == 8'd0))
        else $error("non-final frame is not a release");

    // The command follows its flushed release in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("command did not follow its release");

    // Ready drops only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_stat.full)
        else $error("input stalled with room in queue");

endmodule
